### rtl/core/bdq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared constants, codes and types for the bounded double-ended queue.
// ----------------------------------------------------------------------------
`default_nettype none

package bdq_pkg;

  // Ring store geometry (depth is a power of two so indexes wrap for free)
  localparam int unsigned IDX_W      = 4;
  localparam int unsigned DEPTH      = 1 << IDX_W;
  localparam int unsigned CNT_W      = IDX_W + 1;
  localparam int unsigned WORD_WIDTH = 32;

  // Port field widths
  localparam int unsigned ACTION_W = 3;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned PORT_W   = 32;

  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [WORD_WIDTH-1:0] word_t;

  // Action codes
  localparam logic [ACTION_W-1:0] ACT_PUSH_FRONT = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_PUSH_BACK  = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_PEEK_FRONT = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_PEEK_BACK  = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_POP_FRONT  = 3'd4;
  localparam logic [ACTION_W-1:0] ACT_POP_BACK   = 3'd5;
  localparam logic [ACTION_W-1:0] ACT_CLEAR      = 3'd6;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_WORD  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ERROR = 2'd2;

  // Store access request from the control logic
  typedef struct packed {
    logic  we;
    idx_t  waddr;
    word_t wdata;
    logic  re;
    idx_t  raddr;
  } ram_req_t;

endpackage

`default_nettype wire

### rtl/core/bdq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_ram
// Element store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bdq_ram (
  input  wire logic              clk_i,
  input  wire bdq_pkg::ram_req_t req_i,
  output bdq_pkg::word_t         rdata_o
);

  bdq_pkg::word_t mem [bdq_pkg::DEPTH];
  bdq_pkg::word_t rdata_q;

  // Write the pushed word
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  // Read on request, hold otherwise
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/core/bounded_double_ended_queue.sv
`timescale 1ns / 1ps
// Result: registered, it appears in the cycle after its request is accepted; the
// store read for peek and pop completes in that cycle.
// Throughput: one request per cycle; the single output register, which holds
// the store read data, stalls the input only while a result waits unclaimed.
// Reset: the queue comes up empty with the front index at zero; store
// contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// bounded_double_ended_queue
// Double-ended queue of fixed-width words in a ring store with a front index
// and an occupancy count; push, peek and pop at either end, and clear.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_double_ended_queue (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 in_valid_i,
  output logic                                      in_stall_o,
  input  wire logic [bdq_pkg::ACTION_W-1:0]         action_i,
  input  wire logic [bdq_pkg::PORT_W-1:0]           push_word_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_stall_i,
  output logic      [bdq_pkg::STATUS_W-1:0]         status_o,
  output logic      [bdq_pkg::PORT_W-1:0]           read_word_o
);

  bdq_pkg::idx_t     front_q, front_d;
  bdq_pkg::cnt_t     occ_q, occ_d;
  logic              out_valid_q;
  logic [bdq_pkg::STATUS_W-1:0] status_q, status_d;
  logic              has_word_q;
  bdq_pkg::ram_req_t req;
  bdq_pkg::word_t    rdata;
  logic              accept;
  logic              full, empty;
  bdq_pkg::idx_t     front_m1, front_p1, back_pos, back_last;

  // Take a new request unless a result is stuck in the output register
  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  assign full      = (occ_q == bdq_pkg::CNT_W'(bdq_pkg::DEPTH));
  assign empty     = (occ_q == '0);
  assign front_m1  = front_q - bdq_pkg::IDX_W'(1);
  assign front_p1  = front_q + bdq_pkg::IDX_W'(1);
  assign back_pos  = front_q + occ_q[bdq_pkg::IDX_W-1:0];
  assign back_last = back_pos - bdq_pkg::IDX_W'(1);

  // Decode the action: move indexes, issue the store access, pick status
  always_comb begin
    front_d   = front_q;
    occ_d     = occ_q;
    status_d  = bdq_pkg::ST_ERROR;
    req.we    = 1'b0;
    req.waddr = back_pos;
    req.wdata = push_word_i[bdq_pkg::WORD_WIDTH-1:0];
    req.re    = 1'b0;
    req.raddr = front_q;
    case (action_i)
      bdq_pkg::ACT_PUSH_FRONT: begin
        if (!full) begin
          front_d   = front_m1;
          req.we    = accept;
          req.waddr = front_m1;
          occ_d     = occ_q + bdq_pkg::CNT_W'(1);
          status_d  = bdq_pkg::ST_OK;
        end
      end
      bdq_pkg::ACT_PUSH_BACK: begin
        if (!full) begin
          req.we   = accept;
          occ_d    = occ_q + bdq_pkg::CNT_W'(1);
          status_d = bdq_pkg::ST_OK;
        end
      end
      bdq_pkg::ACT_PEEK_FRONT, bdq_pkg::ACT_POP_FRONT: begin
        if (!empty) begin
          req.re   = accept;
          status_d = bdq_pkg::ST_WORD;
          if (action_i == bdq_pkg::ACT_POP_FRONT) begin
            front_d = front_p1;
            occ_d   = occ_q - bdq_pkg::CNT_W'(1);
          end
        end
      end
      bdq_pkg::ACT_PEEK_BACK, bdq_pkg::ACT_POP_BACK: begin
        if (!empty) begin
          req.re    = accept;
          req.raddr = back_last;
          status_d  = bdq_pkg::ST_WORD;
          if (action_i == bdq_pkg::ACT_POP_BACK) begin
            occ_d = occ_q - bdq_pkg::CNT_W'(1);
          end
        end
      end
      bdq_pkg::ACT_CLEAR: begin
        front_d  = '0;
        occ_d    = '0;
        status_d = bdq_pkg::ST_OK;
      end
      default: begin
      end
    endcase
  end

  bdq_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (req),
    .rdata_o (rdata)
  );

  // Advance queue state and the output register on each accepted request; drop the valid once the result is claimed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q     <= '0;
      occ_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        front_q     <= front_d;
        occ_q       <= occ_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold result payload alongside the store read data
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q   <= status_d;
      has_word_q <= (status_d == bdq_pkg::ST_WORD);
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign read_word_o = has_word_q ? bdq_pkg::PORT_W'(rdata) : '0;

endmodule

`default_nettype wire

### test/tb_bounded_double_ended_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bounded_double_ended_queue
// Self-checking bench for the bounded double-ended queue. Requests are driven
// through the valid/stall input channel and predicted by a ring-buffer model
// kept in the bench. Results are claimed through the output channel and
// compared field by field in order. Directed cases cover the empty queue,
// filling to the bound, the unused action code and clear. A long receiver
// hold-off backs the queue up. Then a long random mix runs with biased action
// profiles and random gaps on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_bounded_double_ended_queue;

  localparam int unsigned RESET_CYCLES   = 10;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES   = 8;
  localparam int unsigned RANDOM_ITEMS   = 450;
  localparam int unsigned PRESSURE_ITEMS = 12;

  // Action mix profiles for the random part
  localparam int unsigned MIX_FILL  = 0;
  localparam int unsigned MIX_DRAIN = 1;
  localparam int unsigned MIX_EVEN  = 2;

  typedef logic [bdq_pkg::ACTION_W-1:0] action_code_t;
  typedef logic [bdq_pkg::PORT_W-1:0]   port_word_t;

  // The one action code the block does not define
  localparam action_code_t ACT_UNUSED = 3'd7;

  typedef struct packed {
    logic [bdq_pkg::STATUS_W-1:0] status;
    port_word_t                   read_word;
  } reply_t;

  logic         clk_i       = 1'b0;
  logic         rst_ni      = 1'b0;
  logic         in_valid_i  = 1'b0;
  action_code_t action_i    = bdq_pkg::ACT_PUSH_FRONT;
  port_word_t   push_word_i = '0;
  logic         out_stall_i = 1'b0;
  logic         in_stall_o;
  logic         out_valid_o;
  logic [bdq_pkg::STATUS_W-1:0] status_o;
  port_word_t   read_word_o;

  // Bench copy of the queue state
  bdq_pkg::word_t ring_words [bdq_pkg::DEPTH];
  bdq_pkg::idx_t  front_idx  = '0;
  bdq_pkg::cnt_t  fill_count = '0;

  reply_t      expected_replies [$];
  int unsigned mismatch_count = 0;
  int unsigned idle_cycles    = 0;
  bit          idle_enable    = 1'b1;
  bit          hold_pending   = 1'b0;

  bounded_double_ended_queue dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .action_i    (action_i),
    .push_word_i (push_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .read_word_o (read_word_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Apply one request to the bench queue and return the reply it should give
  function automatic reply_t apply_queue_action(input action_code_t act,
                                                input port_word_t word);
    reply_t        r;
    bdq_pkg::idx_t slot;
    r.status    = bdq_pkg::ST_ERROR;
    r.read_word = '0;
    case (act)
      bdq_pkg::ACT_PUSH_FRONT: begin
        if (fill_count < bdq_pkg::DEPTH) begin
          front_idx             = front_idx - 1'b1;
          ring_words[front_idx] = word[bdq_pkg::WORD_WIDTH-1:0];
          fill_count            = fill_count + 1'b1;
          r.status              = bdq_pkg::ST_OK;
        end
      end
      bdq_pkg::ACT_PUSH_BACK: begin
        if (fill_count < bdq_pkg::DEPTH) begin
          slot             = bdq_pkg::idx_t'(front_idx + fill_count);
          ring_words[slot] = word[bdq_pkg::WORD_WIDTH-1:0];
          fill_count       = fill_count + 1'b1;
          r.status         = bdq_pkg::ST_OK;
        end
      end
      bdq_pkg::ACT_PEEK_FRONT, bdq_pkg::ACT_POP_FRONT: begin
        if (fill_count != 0) begin
          r.read_word = bdq_pkg::PORT_W'(ring_words[front_idx]);
          r.status    = bdq_pkg::ST_WORD;
          if (act == bdq_pkg::ACT_POP_FRONT) begin
            front_idx  = front_idx + 1'b1;
            fill_count = fill_count - 1'b1;
          end
        end
      end
      bdq_pkg::ACT_PEEK_BACK, bdq_pkg::ACT_POP_BACK: begin
        if (fill_count != 0) begin
          slot        = bdq_pkg::idx_t'(front_idx + fill_count - 1'b1);
          r.read_word = bdq_pkg::PORT_W'(ring_words[slot]);
          r.status    = bdq_pkg::ST_WORD;
          if (act == bdq_pkg::ACT_POP_BACK) begin
            fill_count = fill_count - 1'b1;
          end
        end
      end
      bdq_pkg::ACT_CLEAR: begin
        front_idx  = '0;
        fill_count = '0;
        r.status   = bdq_pkg::ST_OK;
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int unsigned gap_length();
    if ($urandom_range(0, 9) == 0) begin
      return $urandom_range(10, 40);
    end
    return $urandom_range(1, 3);
  endfunction

  function automatic port_word_t rand_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Pick an action, weighting pushes against reads by profile
  function automatic action_code_t pick_action(input int unsigned mix);
    int unsigned roll;
    int unsigned push_pct;
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      return bdq_pkg::ACT_CLEAR;
    end
    if (roll < 6) begin
      return ACT_UNUSED;
    end
    case (mix)
      MIX_FILL:  push_pct = 70;
      MIX_DRAIN: push_pct = 20;
      default:   push_pct = 45;
    endcase
    if ($urandom_range(0, 99) < push_pct) begin
      return $urandom_range(0, 1) ? bdq_pkg::ACT_PUSH_BACK : bdq_pkg::ACT_PUSH_FRONT;
    end
    case ($urandom_range(0, 3))
      0:       return bdq_pkg::ACT_PEEK_FRONT;
      1:       return bdq_pkg::ACT_PEEK_BACK;
      2:       return bdq_pkg::ACT_POP_FRONT;
      default: return bdq_pkg::ACT_POP_BACK;
    endcase
  endfunction

  // Offer one request, hold it until accepted, then maybe idle
  task automatic send_request(input action_code_t act, input port_word_t word);
    int unsigned gap;
    in_valid_i  <= 1'b1;
    action_i    <= act;
    push_word_i <= word;
    do @(posedge clk_i); while (in_stall_o);
    if (idle_enable && $urandom_range(0, 2) == 0) begin
      gap = gap_length();
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Reads and pops on an empty queue, the unused code and clear when empty
  task automatic test_empty_queue();
    send_request(bdq_pkg::ACT_PEEK_FRONT, '1);
    send_request(bdq_pkg::ACT_PEEK_BACK, '0);
    send_request(bdq_pkg::ACT_POP_FRONT, '1);
    send_request(bdq_pkg::ACT_POP_BACK, '0);
    send_request(ACT_UNUSED, '1);
    send_request(bdq_pkg::ACT_CLEAR, '1);
  endtask

  // Fill to the bound from both ends, push past it, read both ends, clear
  task automatic test_fill_to_full();
    port_word_t word;
    for (int unsigned i = 0; i < bdq_pkg::DEPTH; i++) begin
      case (i % 4)
        0:       word = '1;
        1:       word = '0;
        2:       word = 32'hAAAA_AAAA;
        default: word = 32'h5555_5555;
      endcase
      send_request((i % 2) ? bdq_pkg::ACT_PUSH_BACK : bdq_pkg::ACT_PUSH_FRONT, word);
    end
    send_request(bdq_pkg::ACT_PUSH_FRONT, 32'h1234_5678);
    send_request(bdq_pkg::ACT_PUSH_BACK, 32'h8765_4321);
    send_request(bdq_pkg::ACT_POP_FRONT, '0);
    send_request(bdq_pkg::ACT_POP_BACK, '0);
    send_request(bdq_pkg::ACT_CLEAR, '0);
  endtask

  // Hold the receiver off while requests keep coming, so the input stalls
  task automatic test_backpressure();
    hold_pending = 1'b1;
    for (int unsigned i = 0; i < PRESSURE_ITEMS; i++) begin
      send_request((i < PRESSURE_ITEMS / 2) ? bdq_pkg::ACT_PUSH_BACK
                                            : bdq_pkg::ACT_POP_FRONT,
                   rand_word());
    end
  endtask

  // Random chunks with a biased profile; some chunks run without idling
  task automatic test_random_mix();
    int unsigned sent;
    int unsigned chunk_len;
    int unsigned mix;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      chunk_len   = $urandom_range(10, 40);
      mix         = $urandom_range(MIX_FILL, MIX_EVEN);
      idle_enable = ($urandom_range(0, 3) != 0);
      repeat (chunk_len) send_request(pick_action(mix), rand_word());
      sent += chunk_len;
    end
    idle_enable = 1'b1;
  endtask

  // Drain outstanding results and report
  task automatic finish_run();
    in_valid_i <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && expected_replies.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  endtask

  initial begin : stimulus
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_queue();
    test_fill_to_full();
    test_backpressure();
    test_random_mix();
    finish_run();
  end

  // Drive the result stall: random stretches, or one long hold on demand
  initial begin : receiver
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_pending) begin
        hold_pending = 1'b0;
        stall_left   = HOLD_CYCLES;
      end else if (stall_left == 0 && idle_enable && $urandom_range(0, 3) == 0) begin
        stall_left = gap_length();
      end
      out_stall_i <= (stall_left != 0);
      if (stall_left != 0) begin
        stall_left--;
      end
    end
  end

  // Check claimed results in order, then predict newly accepted requests
  always @(posedge clk_i) begin : scoreboard
    reply_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_replies.size() == 0) begin
          $error("result with no pending request: status %0d, read_word 0x%08h",
                 status_o, read_word_o);
          mismatch_count++;
        end else begin
          want = expected_replies.pop_front();
          if (status_o !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, status_o);
            mismatch_count++;
          end
          if (read_word_o !== want.read_word) begin
            $error("read_word mismatch: expected 0x%08h, actual 0x%08h",
                   want.read_word, read_word_o);
            mismatch_count++;
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        expected_replies.push_back(apply_queue_action(action_i, push_word_i));
      end
    end
  end

  // End the run if neither channel moves for too long
  always @(posedge clk_i) begin : watchdog
    if (rst_ni && !(in_valid_i && !in_stall_o) && !(out_valid_o && !out_stall_i)) begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end else begin
      idle_cycles = 0;
    end
  end

endmodule

`default_nettype wire
